@@ hdl/irpw_pkg.sv @@
// ---------------------------------------------------------------------------
// irpw_pkg: shared types and constants for the ir pulse width bit decoder
// Timer and message sizes, register indexes, decoder phases, result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irpw_pkg;

  // sizes
  localparam int unsigned TIMER_BITS   = 16;
  localparam int unsigned MESSAGE_BITS = 8;
  localparam int unsigned IDX_W        = (MESSAGE_BITS > 1) ? $clog2(MESSAGE_BITS) : 1;
  localparam int unsigned CNT_W        = $clog2(MESSAGE_BITS + 1);
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;

  // register reset values
  localparam logic [CFG_W-1:0] SHORT_MIN_RST = CFG_W'(500);
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = CFG_W'(1500);
  localparam logic [CFG_W-1:0] LONG_MIN_RST  = CFG_W'(1500);
  localparam logic [CFG_W-1:0] LONG_MAX_RST  = CFG_W'(2500);
  localparam logic [CFG_W-1:0] BREAK_MIN_RST = CFG_W'(2500);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN = 3'd0,
    REG_SHORT_MAX = 3'd1,
    REG_LONG_MIN  = 3'd2,
    REG_LONG_MAX  = 3'd3,
    REG_BREAK_MIN = 3'd4
  } reg_idx_e;

  // decoder phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MID1  = 3'd1,
    PH_SHRT1 = 3'd2,
    PH_MID0  = 3'd3,
    PH_SHRT0 = 3'd4
  } phase_e;

  // threshold set
  typedef struct packed {
    logic [CFG_W-1:0] short_min;
    logic [CFG_W-1:0] short_max;
    logic [CFG_W-1:0] long_min;
    logic [CFG_W-1:0] long_max;
    logic [CFG_W-1:0] break_min;
  } thresh_t;

  // one result item
  typedef struct packed {
    logic [TIMER_BITS-1:0]   gap;
    logic [2:0]              decode_phase;
    logic                    armed_flag;
    logic                    bit_valid;
    logic                    bit_value;
    logic [IDX_W-1:0]        bit_index;
    logic                    abort_flag;
    logic [MESSAGE_BITS-1:0] message_word;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/ir_pulse_width_bit_decoder_core.sv @@
// ---------------------------------------------------------------------------
// ir_pulse_width_bit_decoder_core: manchester pulse width decoder top level
// Turns edge timestamps into gaps, phases and decoded message bits.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one edge timestamp per item.
//   Output channel: out_valid_o / out_stall_i carry exactly one result item
//   per input item: gap, phase, armed, decoded bit, abort and message word.
//   Thresholds are written through cfg_we_i / cfg_index_i / cfg_data_i
//   while no item is in flight.
//   An accepted item passes the input register, then the decode logic into
//   the result register, which drives the outputs.
//   Throughput: 1 item per cycle while out_stall_i is low; the decoder state
//   is updated by a single subtract, compare and phase step per item.
//   Reset clears the pipeline valids, restores the default thresholds and
//   puts the decoder in idle with the next edge treated as the first one.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_stall_o rises until the result moves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_width_bit_decoder_core
  import irpw_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input items
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [TIMER_BITS-1:0]   edge_time_i,
  // result items
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [TIMER_BITS-1:0]        gap_o,
  output logic [2:0]                   decode_phase_o,
  output logic                         armed_flag_o,
  output logic                         bit_valid_o,
  output logic                         bit_value_o,
  output logic [IDX_W-1:0]             bit_index_o,
  output logic                         abort_flag_o,
  output logic [MESSAGE_BITS-1:0]      message_word_o,
  // configuration
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i
);

  thresh_t               thresh;
  result_t               result;
  logic                  in_vld_q;
  logic [TIMER_BITS-1:0] in_time_q;
  logic                  out_vld_q;
  result_t               out_q;
  logic                  out_ready;
  logic                  fire;
  logic                  in_take;

  // handshake
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // threshold registers
  irpw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thresh_o    (thresh)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_time_q <= edge_time_i;
    end
  end

  // decode logic and state
  irpw_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .edge_time_i (in_time_q),
    .thresh_i    (thresh),
    .result_o    (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign gap_o          = out_q.gap;
  assign decode_phase_o = out_q.decode_phase;
  assign armed_flag_o   = out_q.armed_flag;
  assign bit_valid_o    = out_q.bit_valid;
  assign bit_value_o    = out_q.bit_value;
  assign bit_index_o    = out_q.bit_index;
  assign abort_flag_o   = out_q.abort_flag;
  assign message_word_o = out_q.message_word;

endmodule

`default_nettype wire

@@ hdl/irpw_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// irpw_cfg_regs: threshold register file
// Five 16-bit thresholds written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpw_cfg_regs
  import irpw_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output thresh_t                   thresh_o
);

  thresh_t thresh_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.short_min <= SHORT_MIN_RST;
      thresh_q.short_max <= SHORT_MAX_RST;
      thresh_q.long_min  <= LONG_MIN_RST;
      thresh_q.long_max  <= LONG_MAX_RST;
      thresh_q.break_min <= BREAK_MIN_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SHORT_MIN: thresh_q.short_min <= cfg_data_i;
        REG_SHORT_MAX: thresh_q.short_max <= cfg_data_i;
        REG_LONG_MIN:  thresh_q.long_min  <= cfg_data_i;
        REG_LONG_MAX:  thresh_q.long_max  <= cfg_data_i;
        REG_BREAK_MIN: thresh_q.break_min <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign thresh_o = thresh_q;

endmodule

`default_nettype wire

@@ hdl/irpw_decoder.sv @@
// ---------------------------------------------------------------------------
// irpw_decoder: gap measurement and manchester phase machine
// Holds the decoder state; computes one result per item combinationally
// and commits the new state when the item moves on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpw_decoder
  import irpw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic [TIMER_BITS-1:0] edge_time_i,
  input  wire thresh_t               thresh_i,
  output result_t                    result_o
);

  logic                    first_q, first_d;
  logic [TIMER_BITS-1:0]   last_q;
  phase_e                  phase_q, phase_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    armed_q, armed_d;
  logic [MESSAGE_BITS-1:0] msg_q, msg_d;

  logic [TIMER_BITS-1:0]   gap;
  logic                    is_short, is_long;
  logic                    want_bit, bit_val, full;
  logic                    valid, aborted;

  // gap and pulse classification
  assign gap      = first_q ? '0 : TIMER_BITS'(edge_time_i - last_q);
  assign is_short = (gap > thresh_i.short_min) && (gap < thresh_i.short_max);
  assign is_long  = (gap > thresh_i.long_min) && (gap < thresh_i.long_max);
  assign full     = (count_q >= CNT_W'(MESSAGE_BITS));

  // phase machine next state
  always_comb begin
    phase_d  = phase_q;
    want_bit = 1'b0;
    bit_val  = 1'b0;
    aborted  = 1'b0;
    if (armed_q) begin
      case (phase_q)
        PH_MID1: begin
          if (is_short || is_long) begin
            phase_d  = is_short ? PH_SHRT1 : PH_MID0;
            want_bit = 1'b1;
            bit_val  = 1'b1;
          end
        end
        PH_SHRT1: begin
          if (is_short) begin
            phase_d = PH_MID1;
          end else begin
            aborted = 1'b1;
          end
        end
        PH_MID0: begin
          if (is_short || is_long) begin
            phase_d  = is_short ? PH_SHRT0 : PH_MID1;
            want_bit = 1'b1;
          end else begin
            aborted = 1'b1;
          end
        end
        PH_SHRT0: begin
          if (is_short) begin
            phase_d = PH_MID0;
          end else begin
            aborted = 1'b1;
          end
        end
        default: begin
          phase_d = is_short ? PH_MID1 : PH_IDLE;
        end
      endcase
      // a bit past the end of the message aborts
      if (want_bit && full) begin
        aborted = 1'b1;
      end
    end
    if (aborted) begin
      phase_d = PH_IDLE;
    end
  end

  // bit storage and arming
  assign valid = want_bit && !full;

  always_comb begin
    first_d = 1'b0;
    msg_d   = msg_q;
    count_d = count_q;
    armed_d = armed_q;
    if (valid) begin
      msg_d[count_q[IDX_W-1:0]] = bit_val;
      count_d = count_q + CNT_W'(1);
    end
    if (aborted) begin
      count_d = '0;
      armed_d = 1'b0;
    end
    if (gap > thresh_i.break_min) begin
      armed_d = 1'b1;
    end
  end

  // state commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      last_q  <= '0;
      phase_q <= PH_IDLE;
      count_q <= '0;
      armed_q <= 1'b0;
      msg_q   <= '0;
    end else if (fire_i) begin
      first_q <= first_d;
      last_q  <= edge_time_i;
      phase_q <= phase_d;
      count_q <= count_d;
      armed_q <= armed_d;
      msg_q   <= msg_d;
    end
  end

  // result item
  always_comb begin
    result_o.gap          = gap;
    result_o.decode_phase = phase_d;
    result_o.armed_flag   = armed_d;
    result_o.bit_valid    = valid;
    result_o.bit_value    = valid & bit_val;
    result_o.bit_index    = valid ? count_q[IDX_W-1:0] : '0;
    result_o.abort_flag   = aborted;
    result_o.message_word = msg_d;
  end

endmodule

`default_nettype wire

@@ hdl/irpw_checker.sv @@
// ---------------------------------------------------------------------------
// irpw_checker: port level checks for the pulse width decoder
// Watches the result channel and the consistency of result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpw_checker
  import irpw_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [TIMER_BITS-1:0]   gap_o,
  input wire logic [2:0]              decode_phase_o,
  input wire logic                    armed_flag_o,
  input wire logic                    bit_valid_o,
  input wire logic                    bit_value_o,
  input wire logic [IDX_W-1:0]        bit_index_o,
  input wire logic                    abort_flag_o
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gap_o))
    else $error("stalled result item changed");

  // a decoded bit never comes with an abort or while disarmed
  a_bit_no_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bit_valid_o |-> !abort_flag_o && armed_flag_o)
    else $error("decoded bit with abort or while disarmed");

  // bit fields are zero when no bit was decoded
  a_bit_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bit_valid_o |-> !bit_value_o && (bit_index_o == '0))
    else $error("bit fields set without a decoded bit");

  // an abort returns the phase machine to idle
  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && abort_flag_o |-> decode_phase_o == PH_IDLE)
    else $error("abort left decoder out of idle");

endmodule

bind ir_pulse_width_bit_decoder_core irpw_checker u_irpw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .gap_o          (gap_o),
  .decode_phase_o (decode_phase_o),
  .armed_flag_o   (armed_flag_o),
  .bit_valid_o    (bit_valid_o),
  .bit_value_o    (bit_value_o),
  .bit_index_o    (bit_index_o),
  .abort_flag_o   (abort_flag_o)
);

`default_nettype wire

@@ tb/ir_pulse_width_bit_decoder_core_test.sv @@
// ---------------------------------------------------------------------------
// ir_pulse_width_bit_decoder_core_test: self-checking bench for the decoder
// Feeds edge timestamps (directed edge cases, then Manchester frames with
// random content and noise) under several threshold sets. Each result item
// is compared field by field with an in-bench decoder prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_pulse_width_bit_decoder_core_test;
  import irpw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // dut ports
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [TIMER_BITS-1:0]   edge_time_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [TIMER_BITS-1:0]   gap_o;
  logic [2:0]              decode_phase_o;
  logic                    armed_flag_o;
  logic                    bit_valid_o;
  logic                    bit_value_o;
  logic [IDX_W-1:0]        bit_index_o;
  logic                    abort_flag_o;
  logic [MESSAGE_BITS-1:0] message_word_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i  = '0;

  // stimulus and scoreboard
  logic [TIMER_BITS-1:0] edge_queue [$];
  result_t               expected_results [$];
  logic [TIMER_BITS-1:0] stamp_now;
  bit                    send_idle_en;
  bit                    recv_stall_en;
  int unsigned           send_hold;
  int unsigned           stall_hold;
  int unsigned           fail_count;
  int unsigned           cycle_count;

  // decoder prediction state
  thresh_t                 thr;
  logic                    dec_first_edge;
  logic [TIMER_BITS-1:0]   dec_last_time;
  phase_e                  dec_phase;
  logic [CNT_W-1:0]        dec_count;
  logic                    dec_armed;
  logic [MESSAGE_BITS-1:0] dec_message;

  // gaps that follow the very first edge at the default thresholds
  int unsigned opening_gaps [0:16] = '{1, 2501, 1000, 1000, 1000, 2000, 1000, 1000,
                                      2000, 1000, 2600, 1000, 2000, 1000, 2000,
                                      65535, 501};

  ir_pulse_width_bit_decoder_core i_dut (.*);

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // one edge through the decoder: gap, phase machine, then break test
  function automatic result_t decode_edge(logic [TIMER_BITS-1:0] stamp);
    result_t               r;
    logic [TIMER_BITS-1:0] gap;
    logic                  is_short;
    logic                  is_long;
    logic                  want_bit;
    logic                  want_val;
    r        = '0;
    want_bit = 1'b0;
    want_val = 1'b0;
    gap = dec_first_edge ? '0 : TIMER_BITS'(stamp - dec_last_time);
    dec_first_edge = 1'b0;
    dec_last_time  = stamp;
    is_short = (gap > thr.short_min) && (gap < thr.short_max);
    is_long  = (gap > thr.long_min) && (gap < thr.long_max);
    if (dec_armed) begin
      case (dec_phase)
        PH_MID1: begin
          if (is_short || is_long) begin
            dec_phase = is_short ? PH_SHRT1 : PH_MID0;
            want_bit  = 1'b1;
            want_val  = 1'b1;
          end
        end
        PH_SHRT1: begin
          if (is_short) dec_phase = PH_MID1;
          else r.abort_flag = 1'b1;
        end
        PH_MID0: begin
          if (is_short || is_long) begin
            dec_phase = is_short ? PH_SHRT0 : PH_MID1;
            want_bit  = 1'b1;
          end else begin
            r.abort_flag = 1'b1;
          end
        end
        PH_SHRT0: begin
          if (is_short) dec_phase = PH_MID0;
          else r.abort_flag = 1'b1;
        end
        default: dec_phase = is_short ? PH_MID1 : PH_IDLE;
      endcase
      // a bit past the end of the message aborts instead of being stored
      if (want_bit && dec_count >= MESSAGE_BITS) begin
        r.abort_flag = 1'b1;
      end else if (want_bit) begin
        r.bit_valid  = 1'b1;
        r.bit_value  = want_val;
        r.bit_index  = dec_count[IDX_W-1:0];
        dec_message[dec_count] = want_val;
        dec_count = dec_count + 1'b1;
      end
      if (r.abort_flag) begin
        dec_phase = PH_IDLE;
        dec_count = '0;
        dec_armed = 1'b0;
      end
    end
    if (gap > thr.break_min) dec_armed = 1'b1;
    r.gap          = gap;
    r.decode_phase = dec_phase;
    r.armed_flag   = dec_armed;
    r.message_word = dec_message;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // next edge stamp at the given distance from the previous one
  function automatic void push_gap(int unsigned g);
    stamp_now = stamp_now + g[TIMER_BITS-1:0];
    edge_queue.push_back(stamp_now);
  endfunction

  // random value strictly between lo and hi, any gap if the window is empty
  function automatic int unsigned pick_between(int unsigned lo, int unsigned hi);
    if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    return $urandom_range(0, 65535);
  endfunction

  // break, lead-in short gap, then a random Manchester bit sequence
  function automatic void push_frame();
    phase_e      ph;
    int unsigned nbits;
    int unsigned sent;
    nbits = ($urandom_range(0, 4) == 0) ? MESSAGE_BITS + 1 : $urandom_range(1, MESSAGE_BITS);
    push_gap(pick_between(thr.break_min, 65536));
    push_gap(pick_between(thr.short_min, thr.short_max));
    ph   = PH_MID1;
    sent = 0;
    while (sent < nbits) begin
      // broken frame now and then
      if ($urandom_range(0, 39) == 0) begin
        push_gap($urandom_range(0, 65535));
        return;
      end
      if (ph == PH_SHRT1 || ph == PH_SHRT0 || $urandom_range(0, 1) == 1) begin
        push_gap(pick_between(thr.short_min, thr.short_max));
        case (ph)
          PH_MID1: begin
            ph = PH_SHRT1;
            sent++;
          end
          PH_SHRT1: ph = PH_MID1;
          PH_MID0: begin
            ph = PH_SHRT0;
            sent++;
          end
          default: ph = PH_MID0;
        endcase
      end else begin
        push_gap(pick_between(thr.long_min, thr.long_max));
        ph = (ph == PH_MID1) ? PH_MID0 : PH_MID1;
        sent++;
      end
    end
    // leave mid-bit so the next break resets the machine
    if (ph == PH_MID1) push_gap(pick_between(thr.short_min, thr.short_max));
  endfunction

  function automatic void push_random(int unsigned count);
    int unsigned goal;
    goal = edge_queue.size() + count;
    while (edge_queue.size() < goal) begin
      if ($urandom_range(0, 6) == 0) push_gap($urandom_range(0, 65535));
      else push_frame();
    end
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SHORT_MIN: thr.short_min = value;
      REG_SHORT_MAX: thr.short_max = value;
      REG_LONG_MIN:  thr.long_min  = value;
      REG_LONG_MAX:  thr.long_max  = value;
      default:       thr.break_min = value;
    endcase
  endtask

  task automatic set_thresholds(int unsigned smin, int unsigned smax, int unsigned lmin,
                                int unsigned lmax, int unsigned bmin);
    write_reg(REG_SHORT_MIN, CFG_W'(smin));
    write_reg(REG_SHORT_MAX, CFG_W'(smax));
    write_reg(REG_LONG_MIN, CFG_W'(lmin));
    write_reg(REG_LONG_MAX, CFG_W'(lmax));
    write_reg(REG_BREAK_MIN, CFG_W'(bmin));
  endtask

  // sender holds off until every result is back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (edge_queue.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // input driver: presents queued edges, accepted ones go to the prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(decode_edge(edge_time_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_hold != 0) begin
          in_valid_i <= 1'b0;
          send_hold--;
        end else if (edge_queue.size() != 0) begin
          in_valid_i  <= 1'b1;
          edge_time_i <= edge_queue.pop_front();
          if (send_idle_en && $urandom_range(0, 7) == 0) send_hold = $urandom_range(1, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no edge pending: gap %0d", gap_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("gap", want.gap, gap_o);
          check_field("decode_phase", want.decode_phase, decode_phase_o);
          check_field("armed_flag", want.armed_flag, armed_flag_o);
          check_field("bit_valid", want.bit_valid, bit_valid_o);
          check_field("bit_value", want.bit_value, bit_value_o);
          check_field("bit_index", want.bit_index, bit_index_o);
          check_field("abort_flag", want.abort_flag, abort_flag_o);
          check_field("message_word", want.message_word, message_word_o);
        end
      end
      if (stall_hold != 0) begin
        out_stall_i <= 1'b1;
        stall_hold--;
      end else begin
        out_stall_i <= 1'b0;
        if (recv_stall_en && $urandom_range(0, 6) == 0) stall_hold = $urandom_range(1, 6);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    int unsigned smin;
    int unsigned smax;
    int unsigned lmin;
    int unsigned lmax;
    thr.short_min  = SHORT_MIN_RST;
    thr.short_max  = SHORT_MAX_RST;
    thr.long_min   = LONG_MIN_RST;
    thr.long_max   = LONG_MAX_RST;
    thr.break_min  = BREAK_MIN_RST;
    dec_first_edge = 1'b1;
    dec_last_time  = '0;
    dec_phase      = PH_IDLE;
    dec_count      = '0;
    dec_armed      = 1'b0;
    dec_message    = '0;
    send_hold      = 0;
    stall_hold     = 0;
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_en   = 1'b1;
    recv_stall_en  = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first edge at the top of the counter, wrap, every phase step,
    // aborts in the short phases, break after an abort, ninth bit
    stamp_now = 16'hFFFF;
    edge_queue.push_back(stamp_now);
    foreach (opening_gaps[i]) push_gap(opening_gaps[i]);
    repeat (MESSAGE_BITS + 1) push_gap(2499);
    push_gap(0);
    push_random(100);
    wait_drained();

    // random ordered thresholds
    smin = $urandom_range(50, 400);
    smax = smin + $urandom_range(100, 800);
    lmin = smax + $urandom_range(0, 300);
    lmax = lmin + $urandom_range(200, 2000);
    set_thresholds(smin, smax, lmin, lmax, lmax + $urandom_range(0, 5000));
    push_random(130);
    wait_drained();

    // wide open windows, no idling
    send_idle_en  = 1'b0;
    recv_stall_en = 1'b0;
    set_thresholds(0, 65535, 0, 65535, 0);
    push_random(50);
    wait_drained();

    // nothing can classify
    send_idle_en  = 1'b1;
    recv_stall_en = 1'b1;
    set_thresholds(65535, 65535, 65535, 65535, 65535);
    push_random(40);
    wait_drained();

    // overlapping short and long windows
    set_thresholds(100, 3000, 200, 5000, 6000);
    push_random(110);
    wait_drained();

    // back to defaults, closing stretch at full rate
    send_idle_en  = 1'b0;
    recv_stall_en = 1'b0;
    set_thresholds(SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST, BREAK_MIN_RST);
    push_random(90);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/irpw_pkg.sv
hdl/irpw_cfg_regs.sv
hdl/irpw_decoder.sv
hdl/ir_pulse_width_bit_decoder_core.sv
hdl/irpw_checker.sv
tb/ir_pulse_width_bit_decoder_core_test.sv
